>>> design/thermlut_pkg.sv
// Shared types, widths and helpers for the thermistor table interpolator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package thermlut_pkg;

	localparam int THL_ENTRIES = 16;   // default table depth
	localparam int VOLT_W      = 16;   // breakpoint and sample voltage width
	localparam int TRAW_W      = 8;    // stored temperature width (offset form)
	localparam int TEMP_W      = 10;   // signed working width of a temperature
	localparam int OUT_W       = 9;    // signed result width
	localparam int Q_W         = 8;    // quotient bits: |t1 - t0| never exceeds 255
	localparam int NUM_W       = VOLT_W + Q_W;
	localparam int CNT_W       = $clog2(Q_W);
	localparam int TEMP_OFFSET = 20;

	// One table entry as held in the memory.
	typedef struct packed {
		logic [VOLT_W-1:0] volt;
		logic [TRAW_W-1:0] traw;
	} mem_word_t;

	// Request into the serial divider.
	typedef struct packed {
		logic             go;
		logic [NUM_W-1:0] num_abs;
		logic [VOLT_W-1:0] den;
	} div_req_t;

	// Answer from the serial divider.
	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] quot;
	} div_rsp_t;

	// Stored temperature to degrees Celsius, with the storage offset removed.
	function automatic logic signed [TEMP_W-1:0] ent_temp(input logic [TRAW_W-1:0] raw);
		ent_temp = $signed({2'b00, raw}) - TEMP_W'(TEMP_OFFSET);
	endfunction

endpackage

>>> design/thermlut_mem.sv
// Breakpoint table storage: one write port, one read port, registered read data.
// Depends on thermlut_pkg for the entry type.
`timescale 1ns / 1ps

module thermlut_mem
	import thermlut_pkg::*;
#(
	parameter int DEPTH = THL_ENTRIES,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  mem_word_t     wdata,
	input  logic [AW-1:0] raddr,
	output mem_word_t     rdata
);

	mem_word_t mem_q [DEPTH];
	mem_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/thermlut_div.sv
// Serial restoring divider: one quotient bit per cycle, Q_W quotient bits per division.
// Depends on thermlut_pkg for widths and request/answer types.
`timescale 1ns / 1ps

module thermlut_div
	import thermlut_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsr_q;
	logic [Q_W-1:0]   quot_q;

	logic             ge;
	logic [NUM_W-1:0] rem_nx;
	logic [Q_W-1:0]   quot_nx;

	// The quotient is known to fit in Q_W bits, so the divisor starts aligned
	// to the top quotient bit and moves down one place each step.
	always_comb begin
		ge      = (rem_q >= dsr_q);
		rem_nx  = ge ? (rem_q - dsr_q) : rem_q;
		quot_nx = {quot_q[Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(Q_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q  <= req.num_abs;
			dsr_q  <= NUM_W'({req.den, {(Q_W-1){1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			dsr_q  <= dsr_q >> 1;
			quot_q <= quot_nx;
		end
	end

	assign rsp.done = busy_q && (cnt_q == CNT_W'(Q_W - 1));
	assign rsp.quot = quot_nx;

endmodule

>>> design/thermistor_lut_interpolator.sv
// Top level of the thermistor voltage to temperature converter.
// Depends on thermlut_pkg, thermlut_mem and thermlut_div.
`timescale 1ns / 1ps
//
// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------------------
// input   | in_valid / in_stall | mode, entry_index, entry_voltage_mv,
//         |                     | entry_temp_raw, sample_mv
// output  | out_valid/out_stall | temperature_c (signed, degrees Celsius)
//
// A conversion searches the segments, reading one table entry per cycle from the
// single read port, then passes through a multiply state and the serial divide;
// a voltage outside every segment skips the arithmetic.
// Reset clears only the control state; the table holds garbage until written.
// A result waits in the output register while the next item is taken; a
// conversion that finishes while that register is still full waits for it.

module thermistor_lut_interpolator
	import thermlut_pkg::*;
#(
	parameter int TABLE_ENTRIES = THL_ENTRIES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [3:0]               entry_index,
	input  logic [VOLT_W-1:0]        entry_voltage_mv,
	input  logic [TRAW_W-1:0]        entry_temp_raw,
	input  logic [VOLT_W-1:0]        sample_mv,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  temperature_c
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;

	// Working registers of one conversion.
	logic [IDX_W-1:0]         k_q;        // index of the lower breakpoint under test
	logic [VOLT_W-1:0]        v_q;        // voltage being converted
	logic [VOLT_W-1:0]        first_v_q;
	logic [TRAW_W-1:0]        first_t_q;
	logic [VOLT_W-1:0]        prev_v_q;
	logic [TRAW_W-1:0]        prev_t_q;
	logic signed [TEMP_W-1:0] t0_q;
	logic signed [TEMP_W-1:0] diff_q;
	logic [VOLT_W-1:0]        dv_q;
	logic [VOLT_W-1:0]        den_q;
	logic [OUT_W-1:0]         res_q;

	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;

	// Memory interface.
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	mem_word_t        mem_wdata;
	mem_word_t        mem_rdata;
	logic [IDX_W+3:0] idx_ext;
	logic [IDX_W:0]   k_plus2;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_xfer;
	logic out_xfer;
	logic out_load;
	logic seg_hit;
	logic last_seg;

	logic signed [TEMP_W-1:0] diff_mag;
	logic [Q_W-1:0]           mag8;
	logic signed [TEMP_W-1:0] sum;
	logic signed [TEMP_W-1:0] edge_temp;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Table writes land in the cycle of the transfer; indexes past the table
	// are dropped. The sequencer never reads while a write is taking place.
	assign idx_ext   = (IDX_W + 4)'(entry_index);
	assign mem_waddr = idx_ext[IDX_W-1:0];
	assign mem_we    = in_xfer && !mode && (32'(entry_index) < 32'(TABLE_ENTRIES));
	assign mem_wdata = '{volt: entry_voltage_mv, traw: entry_temp_raw};

	// Read address: entry 0 is fetched during the accepting cycle, entry 1 in
	// the first search cycle, then one entry ahead of the comparison.
	assign k_plus2 = (IDX_W + 1)'(k_q) + (IDX_W + 1)'(2);

	always_comb begin
		case (state_q)
			S_FIRST: mem_raddr = IDX_W'(1);
			S_SCAN:  mem_raddr = k_plus2[IDX_W-1:0];
			default: mem_raddr = '0;
		endcase
	end

	thermlut_mem #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (IDX_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Segment test against the entry that just came out of the memory.
	assign seg_hit  = (v_q >= prev_v_q) && (v_q < mem_rdata.volt);
	assign last_seg = (k_q == IDX_W'(TABLE_ENTRIES - 2));

	// Outside every segment: below the first breakpoint gives the first
	// temperature, anything else the last one (which is on the read port now).
	assign edge_temp = (v_q < first_v_q) ? ent_temp(first_t_q) : ent_temp(mem_rdata.traw);

	// The temperature step is at most 255 in magnitude, so the product of its
	// magnitude and the voltage offset fits NUM_W bits. The divider registers it.
	assign diff_mag = (diff_q < 0) ? -diff_q : diff_q;
	assign mag8     = diff_mag[Q_W-1:0];

	assign div_req.go      = (state_q == S_MUL);
	assign div_req.num_abs = NUM_W'(mag8) * NUM_W'(dv_q);
	assign div_req.den     = den_q;

	thermlut_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// The quotient truncates toward zero because the sign is applied after an
	// unsigned divide of the magnitude.
	assign sum = (diff_q < 0) ? (t0_q - $signed(TEMP_W'(div_rsp.quot)))
	                          : (t0_q + $signed(TEMP_W'(div_rsp.quot)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer && mode) begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (seg_hit) begin
						state_q <= S_MUL;
					end else if (last_seg) begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				v_q <= sample_mv;
				k_q <= '0;
			end
			S_FIRST: begin
				first_v_q <= mem_rdata.volt;
				first_t_q <= mem_rdata.traw;
				prev_v_q  <= mem_rdata.volt;
				prev_t_q  <= mem_rdata.traw;
			end
			S_SCAN: begin
				if (seg_hit) begin
					t0_q   <= ent_temp(prev_t_q);
					diff_q <= ent_temp(mem_rdata.traw) - ent_temp(prev_t_q);
					dv_q   <= v_q - prev_v_q;
					den_q  <= mem_rdata.volt - prev_v_q;
				end else if (last_seg) begin
					res_q <= edge_temp[OUT_W-1:0];
				end else begin
					prev_v_q <= mem_rdata.volt;
					prev_t_q <= mem_rdata.traw;
					k_q      <= k_q + IDX_W'(1);
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					res_q <= sum[OUT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign temperature_c = $signed(out_data_q);

`ifndef SYNTHESIS
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_convert_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && mode) |=> (state_q == S_FIRST))
		else $error("convert transfer did not start the search");

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !mode) |=> (state_q == S_IDLE) && !$past(out_load))
		else $error("table write left the idle state");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("result dropped while output register was full");

	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_DIV) && !div_rsp.done)
		else $error("divider did not start after the multiply");
`endif

endmodule
